/* rtl/core/humidity_sensor_sequencer_macros.svh */
// assertion helpers for the humidity sensor sequencer
// both expect clk and rst_n in the enclosing scope
`ifndef HUMIDITY_SENSOR_SEQUENCER_MACROS_SVH
`define HUMIDITY_SENSOR_SEQUENCER_MACROS_SVH

// same-cycle implication
`define HSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hss_pkg.sv */
`timescale 1ns / 1ps

package hss_pkg;

    localparam int COEF_W    = 21;
    localparam int H_W       = 13;
    localparam int MUL_IN_W  = 25;
    localparam int PROD_W    = 2 * MUL_IN_W;
    localparam int ACC_W     = 48;
    localparam int TEMP_W    = 15;
    localparam int HUM_W     = 18;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_IDENTIFY = 2'd0,
        OP_START    = 2'd1,
        OP_HEATER   = 2'd2,
        OP_POLL     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECTED_ID = 2'd0,
        REG_COEF_ZERO   = 2'd1,
        REG_COEF_LINEAR = 2'd2,
        REG_COEF_SQUARE = 2'd3
    } reg_idx_t;

    localparam logic [2:0] PH_NOTINIT = 3'd0;
    localparam logic [2:0] PH_RELAX   = 3'd1;
    localparam logic [2:0] PH_BUSY    = 3'd2;
    localparam logic [2:0] PH_READY   = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [7:0] WV_TEMP_START = 8'h11;
    localparam logic [7:0] WV_HUM_START  = 8'h01;
    localparam logic [7:0] WV_HEAT_ON    = 8'h02;
    localparam logic [7:0] WV_HEAT_OFF   = 8'h00;

    localparam logic [7:0]  EXPECTED_ID_RST = 8'h50;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST   = -21'sd313550;
    localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST = 21'sd26267;
    localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST = -21'sd258;

    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd1600;
    localparam logic signed [H_W-1:0]    HUM_OFFSET  = 13'sd384;
    localparam logic signed [HUM_W-1:0]  HUM_MIN     = -18'sd2048;
    localparam logic signed [HUM_W-1:0]  HUM_MAX     = 18'sd92160;

    typedef struct packed {
        logic signed [COEF_W-1:0] zero;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] square;
    } hss_coef_t;

endpackage

/* rtl/core/hss_intf.sv */
`timescale 1ns / 1ps

interface hss_evt_if;
    import hss_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       read_ok;
    logic       write_ok;
    logic [7:0] id_byte;
    logic [7:0] status_byte;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic [7:0] config_byte;
    logic       heater_on;

    modport source (output valid, op, read_ok, write_ok, id_byte, status_byte, data_high,
                    data_low, config_byte, heater_on, input ready);
    modport sink (input valid, op, read_ok, write_ok, id_byte, status_byte, data_high,
                  data_low, config_byte, heater_on, output ready);
endinterface

interface hss_rsp_if;
    import hss_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic [2:0]               sensor_status;
    logic                     write_request;
    logic [7:0]               write_value;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [HUM_W-1:0]  humidity;

    modport source (output valid, accepted, sensor_status, write_request, write_value,
                    temperature, humidity, input ready);
    modport sink (input valid, accepted, sensor_status, write_request, write_value,
                  temperature, humidity, output ready);
endinterface

interface hss_cfg_if;
    import hss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/hss_humidity_unit.sv */
`timescale 1ns / 1ps

module hss_humidity_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hss_pkg::H_W-1:0]    h,
    input  hss_pkg::hss_coef_t                coef,
    output logic                              done,
    output logic signed [hss_pkg::HUM_W-1:0]  result
);
    import hss_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE,
        U_SQUARE,
        U_SQR_TERM,
        U_LIN_TERM,
        U_LIN_ACC,
        U_ROUND
    } ustate_t;

    ustate_t                    state_reg;
    logic signed [H_W-1:0]      h_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [HUM_W-1:0]    result_reg;
    logic                       done_reg;

    logic signed [MUL_IN_W-1:0] mul_a;
    logic signed [MUL_IN_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    acc_init;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-17:0]   scaled;
    logic signed [HUM_W-1:0]    result_next;

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            U_SQUARE:
            begin
                mul_a = {{(MUL_IN_W-H_W){h_reg[H_W-1]}}, h_reg};
                mul_b = {{(MUL_IN_W-H_W){h_reg[H_W-1]}}, h_reg};
            end
            U_SQR_TERM:
            begin
                mul_a = {{(MUL_IN_W-COEF_W){coef.square[COEF_W-1]}}, coef.square};
                mul_b = prod_reg[MUL_IN_W-1:0];
            end
            U_LIN_TERM:
            begin
                mul_a = {{(MUL_IN_W-COEF_W){coef.linear[COEF_W-1]}}, coef.linear};
                mul_b = {{(MUL_IN_W-H_W){h_reg[H_W-1]}}, h_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // h * 2^20 - c0 * 2^8
    assign acc_init = ({{(ACC_W-H_W){h[H_W-1]}}, h} <<< 20)
                    - ({{(ACC_W-COEF_W){coef.zero[COEF_W-1]}}, coef.zero} <<< 8);

    // round half up to 1/256, then clamp
    assign rnd    = acc_reg + ACC_W'(32768);
    assign scaled = rnd[ACC_W-1:16];

    always_comb
    begin
        priority if (scaled < (ACC_W-16)'(HUM_MIN))
            result_next = HUM_MIN;
        else if (scaled > (ACC_W-16)'(HUM_MAX))
            result_next = HUM_MAX;
        else
            result_next = scaled[HUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            done_reg   <= 1'b0;
            h_reg      <= '0;
            prod_reg   <= '0;
            acc_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= h;
                        acc_reg   <= acc_init;
                        state_reg <= U_SQUARE;
                    end
                end
                U_SQUARE:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= U_SQR_TERM;
                end
                U_SQR_TERM:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= U_LIN_TERM;
                end
                U_LIN_TERM:
                begin
                    acc_reg   <= acc_reg - prod_reg[ACC_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= U_LIN_ACC;
                end
                U_LIN_ACC:
                begin
                    acc_reg   <= acc_reg - (prod_reg[ACC_W-1:0] <<< 4);
                    state_reg <= U_ROUND;
                end
                U_ROUND:
                begin
                    result_reg <= result_next;
                    done_reg   <= 1'b1;
                    state_reg  <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/core/humidity_sensor_sequencer.sv */
`timescale 1ns / 1ps
// a request is held in pending registers, then loaded into the output register
// once it is free; a poll that completes humidity first runs five steps of the
// shared multiplier and rounding unit; no new request is taken before that load
// the output register lets a new request in while the previous result waits
// reset: phase not initialized, stores zero, registers at their defaults

module humidity_sensor_sequencer (
    input  logic      clk,
    input  logic      rst_n,
    hss_evt_if.sink   evt,
    hss_rsp_if.source rsp,
    hss_cfg_if.sink   cfg
);
    import hss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } state_t;

    state_t                   state_reg;
    logic [2:0]               phase_reg;
    logic signed [TEMP_W-1:0] temp_store_reg;
    logic signed [HUM_W-1:0]  hum_store_reg;
    logic [7:0]               expected_id_reg;
    hss_coef_t                coef_reg;

    logic                     pend_accepted_reg;
    logic                     pend_wreq_reg;
    logic [7:0]               pend_wval_reg;

    logic                     rsp_valid_reg;
    logic                     rsp_accepted_reg;
    logic [2:0]               rsp_status_reg;
    logic                     rsp_wreq_reg;
    logic [7:0]               rsp_wval_reg;
    logic signed [TEMP_W-1:0] rsp_temp_reg;
    logic signed [HUM_W-1:0]  rsp_hum_reg;

    logic                     evt_fire;
    logic                     rsp_load;
    logic [2:0]               phase_next;
    logic signed [TEMP_W-1:0] temp_next;
    logic                     accepted_next;
    logic                     wreq_next;
    logic [7:0]               wval_next;
    logic                     hum_start;
    logic [15:0]              raw;
    logic signed [H_W-1:0]    h_val;
    logic                     unit_done;
    logic signed [HUM_W-1:0]  unit_result;

    assign evt.ready = (state_reg == ST_IDLE);
    assign evt_fire  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    // output register free to take the pending result
    assign rsp_load  = (state_reg == ST_SEND) && (!rsp_valid_reg || rsp.ready);

    assign raw   = {evt.data_high, evt.data_low};
    assign h_val = $signed({1'b0, raw[15:4]}) - HUM_OFFSET;

    // event decode against the current phase
    always_comb
    begin
        phase_next    = phase_reg;
        temp_next     = temp_store_reg;
        accepted_next = 1'b0;
        wreq_next     = 1'b0;
        wval_next     = 8'h00;
        hum_start     = 1'b0;
        unique case (op_t'(evt.op))
            OP_IDENTIFY:
            begin
                phase_next = PH_NOTINIT;
                if (evt.read_ok && (evt.id_byte == expected_id_reg))
                begin
                    phase_next    = PH_RELAX;
                    accepted_next = 1'b1;
                end
            end
            OP_START:
            begin
                if (phase_reg == PH_RELAX)
                begin
                    wreq_next     = 1'b1;
                    wval_next     = WV_TEMP_START;
                    accepted_next = evt.write_ok;
                    phase_next    = evt.write_ok ? PH_BUSY : PH_ERROR;
                end
            end
            OP_HEATER:
            begin
                if (phase_reg == PH_RELAX)
                begin
                    wreq_next     = 1'b1;
                    wval_next     = evt.heater_on ? WV_HEAT_ON : WV_HEAT_OFF;
                    accepted_next = evt.write_ok;
                end
            end
            OP_POLL:
            begin
                if (phase_reg == PH_BUSY)
                begin
                    if (!evt.read_ok)
                        phase_next = PH_ERROR;
                    else if (!evt.status_byte[0])
                    begin
                        if (evt.config_byte[4])
                        begin
                            // temperature mode finished, kick off humidity
                            temp_next  = $signed({1'b0, raw[15:2]}) - TEMP_OFFSET;
                            wreq_next  = 1'b1;
                            wval_next  = WV_HUM_START;
                            phase_next = evt.write_ok ? PH_BUSY : PH_ERROR;
                        end
                        else
                        begin
                            hum_start  = 1'b1;
                            phase_next = PH_READY;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    hss_humidity_unit u_hum (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (evt_fire && hum_start),
        .h      (h_val),
        .coef   (coef_reg),
        .done   (unit_done),
        .result (unit_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= EXPECTED_ID_RST;
            coef_reg.zero   <= COEF_ZERO_RST;
            coef_reg.linear <= COEF_LINEAR_RST;
            coef_reg.square <= COEF_SQUARE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_EXPECTED_ID: expected_id_reg <= cfg.data[7:0];
                REG_COEF_ZERO:   coef_reg.zero   <= $signed(cfg.data);
                REG_COEF_LINEAR: coef_reg.linear <= $signed(cfg.data);
                REG_COEF_SQUARE: coef_reg.square <= $signed(cfg.data);
                default:         expected_id_reg <= expected_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_NOTINIT;
            temp_store_reg    <= '0;
            hum_store_reg     <= '0;
            pend_accepted_reg <= 1'b0;
            pend_wreq_reg     <= 1'b0;
            pend_wval_reg     <= '0;
            rsp_valid_reg     <= 1'b0;
            rsp_accepted_reg  <= 1'b0;
            rsp_status_reg    <= '0;
            rsp_wreq_reg      <= 1'b0;
            rsp_wval_reg      <= '0;
            rsp_temp_reg      <= '0;
            rsp_hum_reg       <= '0;
        end
        else
        begin
            if (rsp.ready && !rsp_load)
                rsp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (evt_fire)
                    begin
                        phase_reg         <= phase_next;
                        temp_store_reg    <= temp_next;
                        pend_accepted_reg <= accepted_next;
                        pend_wreq_reg     <= wreq_next;
                        pend_wval_reg     <= wval_next;
                        state_reg         <= hum_start ? ST_CALC : ST_SEND;
                    end
                end
                ST_CALC:
                begin
                    if (unit_done)
                    begin
                        hum_store_reg <= unit_result;
                        state_reg     <= ST_SEND;
                    end
                end
                ST_SEND:
                begin
                    // wait for the output register to free up
                    if (rsp_load)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_accepted_reg <= pend_accepted_reg;
                        rsp_status_reg   <= phase_reg;
                        rsp_wreq_reg     <= pend_wreq_reg;
                        rsp_wval_reg     <= pend_wval_reg;
                        rsp_temp_reg     <= temp_store_reg;
                        rsp_hum_reg      <= hum_store_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.accepted      = rsp_accepted_reg;
    assign rsp.sensor_status = rsp_status_reg;
    assign rsp.write_request = rsp_wreq_reg;
    assign rsp.write_value   = rsp_wval_reg;
    assign rsp.temperature   = rsp_temp_reg;
    assign rsp.humidity      = rsp_hum_reg;

endmodule

/* rtl/core/hss_checker.sv */
`timescale 1ns / 1ps
`include "humidity_sensor_sequencer_macros.svh"

module hss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_valid,
    input logic       evt_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       accepted,
    input logic [2:0] sensor_status,
    input logic       write_request,
    input logic [7:0] write_value
);
    import hss_pkg::*;

    // one request in flight at a time
    `HSS_ASSERT_NEXT(a_busy_after_req, evt_valid && evt_ready, !evt_ready, "ready after request")

    // an accepted answer comes from a write or from a matching identify
    `HSS_ASSERT_IMPL(a_accept_source, rsp_valid && accepted && !write_request, sensor_status == PH_RELAX, "accept without write or identify")

    // no positive answer while uninitialized or in error
    `HSS_ASSERT_IMPL(a_no_accept_bad_phase, rsp_valid && (sensor_status == PH_NOTINIT || sensor_status == PH_ERROR), !accepted, "accept in bad phase")

    // a stalled result holds
    `HSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(write_value) && $stable(sensor_status), "stalled result changed")

endmodule

bind humidity_sensor_sequencer hss_checker u_hss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt_valid     (evt.valid),
    .evt_ready     (evt.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .accepted      (rsp.accepted),
    .sensor_status (rsp.sensor_status),
    .write_request (rsp.write_request),
    .write_value   (rsp.write_value)
);

/* tb/sv/humidity_sensor_sequencer_tb.sv */
`timescale 1ns / 1ps

module humidity_sensor_sequencer_tb;
    import hss_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 40;
    localparam int NOT_READY_BIT   = 0;
    localparam int TEMP_MODE_BIT   = 4;
    localparam logic [COEF_W-1:0] COEF_MAX = 21'h0F_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 21'h10_0000;

    typedef struct packed {
        op_t        op;
        logic       read_ok;
        logic       write_ok;
        logic [7:0] id_byte;
        logic [7:0] status_byte;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [7:0] config_byte;
        logic       heater_on;
    } sensor_event_t;

    typedef struct packed {
        logic                     accepted;
        logic [2:0]               sensor_status;
        logic                     write_request;
        logic [7:0]               write_value;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [HUM_W-1:0]  humidity;
    } reading_t;

    logic clk;
    logic rst_n;

    hss_evt_if evt_if ();
    hss_rsp_if rsp_if ();
    hss_cfg_if cfg_if ();

    humidity_sensor_sequencer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sensor model state kept by the testbench
    logic [2:0]               phase_q     = PH_NOTINIT;
    logic signed [TEMP_W-1:0] temp_q      = '0;
    logic signed [HUM_W-1:0]  hum_q       = '0;
    logic [7:0]               exp_id_q    = EXPECTED_ID_RST;
    logic signed [COEF_W-1:0] coef_zero_q = COEF_ZERO_RST;
    logic signed [COEF_W-1:0] coef_lin_q  = COEF_LINEAR_RST;
    logic signed [COEF_W-1:0] coef_sq_q   = COEF_SQUARE_RST;

    reading_t expected_readings[$];

    int fail_count      = 0;
    int events_sent     = 0;
    int readings_seen   = 0;
    int reg_writes      = 0;
    int temp_done_count = 0;
    int hum_done_count  = 0;
    int idle_cycles     = 0;
    int src_idle_pct    = 0;
    int snk_idle_pct    = 0;
    logic [7:0] id_setting = EXPECTED_ID_RST;

    function automatic logic signed [HUM_W-1:0] corrected_humidity(input int h);
        longint v;
        longint r;
        v = longint'(h) * 64'sd1048576
            - longint'(coef_sq_q) * h * h
            - longint'(coef_lin_q) * h * 16
            - longint'(coef_zero_q) * 256;
        // round half up, arithmetic shift floors
        r = (v + 32768) >>> 16;
        if (r < longint'(HUM_MIN))
            r = longint'(HUM_MIN);
        if (r > longint'(HUM_MAX))
            r = longint'(HUM_MAX);
        return r[HUM_W-1:0];
    endfunction

    function automatic reading_t predict_reading(input sensor_event_t e);
        reading_t    r;
        logic [15:0] raw;
        r = '0;
        raw = {e.data_high, e.data_low};
        case (e.op)
            OP_IDENTIFY:
            begin
                phase_q = PH_NOTINIT;
                if (e.read_ok && e.id_byte == exp_id_q)
                begin
                    phase_q = PH_RELAX;
                    r.accepted = 1'b1;
                end
            end
            OP_START:
            begin
                if (phase_q == PH_RELAX)
                begin
                    r.write_request = 1'b1;
                    r.write_value = WV_TEMP_START;
                    r.accepted = e.write_ok;
                    phase_q = e.write_ok ? PH_BUSY : PH_ERROR;
                end
            end
            OP_HEATER:
            begin
                if (phase_q == PH_RELAX)
                begin
                    r.write_request = 1'b1;
                    r.write_value = e.heater_on ? WV_HEAT_ON : WV_HEAT_OFF;
                    r.accepted = e.write_ok;
                end
            end
            default:
            begin
                if (phase_q == PH_BUSY)
                begin
                    if (!e.read_ok)
                        phase_q = PH_ERROR;
                    else if (!e.status_byte[NOT_READY_BIT])
                    begin
                        if (e.config_byte[TEMP_MODE_BIT])
                        begin
                            temp_q = TEMP_W'($signed({1'b0, raw[15:2]}) - TEMP_OFFSET);
                            r.write_request = 1'b1;
                            r.write_value = WV_HUM_START;
                            phase_q = e.write_ok ? PH_BUSY : PH_ERROR;
                            temp_done_count++;
                        end
                        else
                        begin
                            hum_q = corrected_humidity(int'(raw[15:4]) - 384);
                            phase_q = PH_READY;
                            hum_done_count++;
                        end
                    end
                end
            end
        endcase
        r.sensor_status = phase_q;
        r.temperature = temp_q;
        r.humidity = hum_q;
        return r;
    endfunction

    function automatic void report_field(input string name, input longint want,
                                         input longint got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // observes all three channels: predicts, checks, and guards against a hang
    always @(posedge clk)
    begin : monitor
        sensor_event_t seen;
        reading_t      want;
        logic          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready)
            begin
                moved = 1'b1;
                reg_writes++;
                case (reg_idx_t'(cfg_if.index))
                    REG_EXPECTED_ID: exp_id_q = cfg_if.data[7:0];
                    REG_COEF_ZERO:   coef_zero_q = cfg_if.data;
                    REG_COEF_LINEAR: coef_lin_q = cfg_if.data;
                    default:         coef_sq_q = cfg_if.data;
                endcase
            end
            if (evt_if.valid && evt_if.ready)
            begin
                moved = 1'b1;
                seen.op          = op_t'(evt_if.op);
                seen.read_ok     = evt_if.read_ok;
                seen.write_ok    = evt_if.write_ok;
                seen.id_byte     = evt_if.id_byte;
                seen.status_byte = evt_if.status_byte;
                seen.data_high   = evt_if.data_high;
                seen.data_low    = evt_if.data_low;
                seen.config_byte = evt_if.config_byte;
                seen.heater_on   = evt_if.heater_on;
                expected_readings.push_back(predict_reading(seen));
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                moved = 1'b1;
                if (expected_readings.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: reading with no request outstanding, expected none actual %h",
                                 $time, rsp_if.sensor_status);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    readings_seen++;
                    report_field("accepted", longint'(want.accepted),
                                 longint'(rsp_if.accepted));
                    report_field("sensor_status", longint'(want.sensor_status),
                                 longint'(rsp_if.sensor_status));
                    report_field("write_request", longint'(want.write_request),
                                 longint'(rsp_if.write_request));
                    report_field("write_value", longint'(want.write_value),
                                 longint'(rsp_if.write_value));
                    report_field("temperature", longint'(want.temperature),
                                 longint'(rsp_if.temperature));
                    report_field("humidity", longint'(want.humidity),
                                 longint'(rsp_if.humidity));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
        rsp_if.ready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);

    function automatic sensor_event_t random_event();
        sensor_event_t e;
        e.op          = op_t'($urandom_range(3));
        e.read_ok     = 1'($urandom_range(1));
        e.write_ok    = 1'($urandom_range(1));
        e.id_byte     = 8'($urandom_range(255));
        e.status_byte = 8'($urandom_range(255));
        e.data_high   = 8'($urandom_range(255));
        e.data_low    = 8'($urandom_range(255));
        e.config_byte = 8'($urandom_range(255));
        e.heater_on   = 1'($urandom_range(1));
        return e;
    endfunction

    function automatic sensor_event_t make_event(input op_t op, input logic rd, input logic wr,
                                                 input logic [7:0] idb, input logic [7:0] stb,
                                                 input logic [15:0] raw,
                                                 input logic [7:0] cfgb, input logic heat);
        sensor_event_t e;
        e.op          = op;
        e.read_ok     = rd;
        e.write_ok    = wr;
        e.id_byte     = idb;
        e.status_byte = stb;
        e.data_high   = raw[15:8];
        e.data_low    = raw[7:0];
        e.config_byte = cfgb;
        e.heater_on   = heat;
        return e;
    endfunction

    // valid stays high from one request to the next unless a gap is drawn
    task automatic send_event(input sensor_event_t e);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(posedge clk);
        end
        evt_if.valid       <= 1'b1;
        evt_if.op          <= e.op;
        evt_if.read_ok     <= e.read_ok;
        evt_if.write_ok    <= e.write_ok;
        evt_if.id_byte     <= e.id_byte;
        evt_if.status_byte <= e.status_byte;
        evt_if.data_high   <= e.data_high;
        evt_if.data_low    <= e.data_low;
        evt_if.config_byte <= e.config_byte;
        evt_if.heater_on   <= e.heater_on;
        @(posedge clk);
        while (!evt_if.ready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic wait_for_readings();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_block(input logic [7:0] id, input logic [COEF_W-1:0] c0,
                                   input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2);
        wait_for_readings();
        // upper data bits are don't-care for the id register
        write_reg(REG_EXPECTED_ID, {13'($urandom), id});
        write_reg(REG_COEF_ZERO, c0);
        write_reg(REG_COEF_LINEAR, c1);
        write_reg(REG_COEF_SQUARE, c2);
        id_setting = id;
    endtask

    // mostly complete measurement sequences with random content, some noise
    task automatic run_traffic(input int n);
        int            stop_at;
        sensor_event_t e;
        stop_at = events_sent + n;
        while (events_sent < stop_at)
        begin
            if ($urandom_range(9) < 2)
                send_event(random_event());
            else
            begin
                e = random_event();
                e.op = OP_IDENTIFY;
                e.read_ok = ($urandom_range(15) != 0);
                if ($urandom_range(7) != 0)
                    e.id_byte = id_setting;
                send_event(e);
                if ($urandom_range(3) == 0)
                begin
                    e = random_event();
                    e.op = OP_HEATER;
                    e.write_ok = ($urandom_range(7) != 0);
                    send_event(e);
                end
                e = random_event();
                e.op = OP_START;
                e.write_ok = ($urandom_range(15) != 0);
                send_event(e);
                // temperature poll first, then humidity
                for (int k = 0; k < 2; k++)
                begin
                    repeat ($urandom_range(2))
                    begin
                        e = random_event();
                        e.op = OP_POLL;
                        e.read_ok = 1'b1;
                        e.status_byte[NOT_READY_BIT] = 1'b1;
                        send_event(e);
                    end
                    e = random_event();
                    e.op = OP_POLL;
                    e.read_ok = ($urandom_range(15) != 0);
                    e.status_byte[NOT_READY_BIT] = 1'b0;
                    e.config_byte[TEMP_MODE_BIT] = (k == 0);
                    if (k == 0)
                        e.write_ok = ($urandom_range(15) != 0);
                    send_event(e);
                end
            end
        end
    endtask

    task automatic test_directed_events();
        src_idle_pct = 22;
        snk_idle_pct = 80;
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h50, 8'h00, 16'h1234, 8'h10, 1'b0));
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_HEATER,   1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b1));
        // identify with failed read, then with a wrong id
        send_event(make_event(OP_IDENTIFY, 1'b0, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b1, 8'h51, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b0, 8'h50, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));
        send_event(make_event(OP_HEATER,   1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1));
        send_event(make_event(OP_HEATER,   1'b1, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0));
        // start write failure, start while in error
        send_event(make_event(OP_START,    1'b1, 1'b0, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_START,    1'b0, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1));
        send_event(make_event(OP_POLL,     1'b0, 1'b1, 8'h00, 8'h00, 16'h8000, 8'h10, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h00, 8'hFF, 16'hFFFF, 8'hFF, 1'b0));
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h00, 8'hFE, 16'hFFFF, 8'hFF, 1'b0));
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h00, 8'hFE, 16'hFFFF, 8'hEF, 1'b1));
        // ready holds until the next identify
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h10, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        // humidity start write fails after temperature is stored
        send_event(make_event(OP_POLL,     1'b1, 1'b0, 8'h00, 8'h00, 16'h0000, 8'h10, 1'b0));
        send_event(make_event(OP_IDENTIFY, 1'b1, 1'b1, 8'h50, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_START,    1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
        send_event(make_event(OP_POLL,     1'b1, 1'b1, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0));
    endtask

    task automatic test_traffic_max_coefs();
        configure_block(8'hFF, COEF_MAX, COEF_MAX, COEF_MAX);
        run_traffic(330);
    endtask

    task automatic test_traffic_min_coefs();
        src_idle_pct = 80;
        snk_idle_pct = 22;
        configure_block(8'h00, COEF_MIN, COEF_MIN, COEF_MIN);
        run_traffic(330);
    endtask

    task automatic test_traffic_random_coefs();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (2)
        begin
            configure_block(8'($urandom_range(255)), COEF_W'($urandom), COEF_W'($urandom),
                            COEF_W'($urandom));
            run_traffic(170);
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        evt_if.valid       = 1'b0;
        evt_if.op          = OP_IDENTIFY;
        evt_if.read_ok     = 1'b0;
        evt_if.write_ok    = 1'b0;
        evt_if.id_byte     = '0;
        evt_if.status_byte = '0;
        evt_if.data_high   = '0;
        evt_if.data_low    = '0;
        evt_if.config_byte = '0;
        evt_if.heater_on   = 1'b0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_EXPECTED_ID;
        cfg_if.data        = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_events();
        test_traffic_max_coefs();
        test_traffic_min_coefs();
        test_traffic_random_coefs();

        wait_for_readings();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            fail_count++;
            $display("%0t: readings outstanding, expected 0 actual %0d", $time,
                     expected_readings.size());
        end
        $display("checked %0d readings from %0d events across %0d register writes",
                 readings_seen, events_sent, reg_writes);
        $display("%0d temperature and %0d humidity conversions completed, %0d mismatches",
                 temp_done_count, hum_done_count, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
